// File: rtl/core/tbw_pkg.sv
// Shared constants and types for the triangle barycentric weight pipeline.
package tbw_pkg;

  localparam int TBW_COORD_BITS = 16;
  localparam int TBW_FRAC_BITS  = 16;
  localparam int NUM_COORDS     = 12;
  localparam int WEIGHT_BITS    = 32;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic neg_a;
    logic neg_b;
    logic degenerate;
  } tbw_tag_t;

endpackage

// File: rtl/core/tbw_edge_dots.sv
// Edge vectors relative to the third vertex and their five dot products, three stages.
module tbw_edge_dots #(
  parameter int COORD_BITS = tbw_pkg::TBW_COORD_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [tbw_pkg::NUM_COORDS*COORD_BITS-1:0]   coords,
  output logic                                        out_valid,
  output logic signed [2*COORD_BITS+3:0]              m00,
  output logic signed [2*COORD_BITS+3:0]              m01,
  output logic signed [2*COORD_BITS+3:0]              m11,
  output logic signed [2*COORD_BITS+3:0]              r0,
  output logic signed [2*COORD_BITS+3:0]              r1
);
  import tbw_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 2;

  logic signed [DIFF_W-1:0] e0 [3];
  logic signed [DIFF_W-1:0] e1 [3];
  logic signed [DIFF_W-1:0] qd [3];
  logic signed [PROD_W-1:0] p00 [3];
  logic signed [PROD_W-1:0] p01 [3];
  logic signed [PROD_W-1:0] p11 [3];
  logic signed [PROD_W-1:0] pr0 [3];
  logic signed [PROD_W-1:0] pr1 [3];
  logic v1;
  logic v2;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: differences, stage 2: products, stage 3: sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= $signed({coords[i*COORD_BITS+COORD_BITS-1], coords[i*COORD_BITS +: COORD_BITS]})
               - $signed({coords[(6+i)*COORD_BITS+COORD_BITS-1],
                          coords[(6+i)*COORD_BITS +: COORD_BITS]});
        e1[i] <= $signed({coords[(3+i)*COORD_BITS+COORD_BITS-1],
                          coords[(3+i)*COORD_BITS +: COORD_BITS]})
               - $signed({coords[(6+i)*COORD_BITS+COORD_BITS-1],
                          coords[(6+i)*COORD_BITS +: COORD_BITS]});
        qd[i] <= $signed({coords[(9+i)*COORD_BITS+COORD_BITS-1],
                          coords[(9+i)*COORD_BITS +: COORD_BITS]})
               - $signed({coords[(6+i)*COORD_BITS+COORD_BITS-1],
                          coords[(6+i)*COORD_BITS +: COORD_BITS]});
        p00[i] <= e0[i] * e0[i];
        p01[i] <= e0[i] * e1[i];
        p11[i] <= e1[i] * e1[i];
        pr0[i] <= e0[i] * qd[i];
        pr1[i] <= e1[i] * qd[i];
      end
      m00 <= DOT_W'(p00[0]) + DOT_W'(p00[1]) + DOT_W'(p00[2]);
      m01 <= DOT_W'(p01[0]) + DOT_W'(p01[1]) + DOT_W'(p01[2]);
      m11 <= DOT_W'(p11[0]) + DOT_W'(p11[1]) + DOT_W'(p11[2]);
      r0  <= DOT_W'(pr0[0]) + DOT_W'(pr0[1]) + DOT_W'(pr0[2]);
      r1  <= DOT_W'(pr1[0]) + DOT_W'(pr1[1]) + DOT_W'(pr1[2]);
    end
  end

endmodule

// File: rtl/core/tbw_wide_mul.sv
// Signed wide multiplier split into four half-width partial products over two stages.
module tbw_wide_mul #(
  parameter int OP_W = 2 * tbw_pkg::TBW_COORD_BITS + 4
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic signed [2*OP_W-1:0] p
);
  import tbw_pkg::*;

  localparam int LO_W = (OP_W + 1) / 2;
  localparam int HI_W = OP_W - LO_W;
  localparam int P_W  = 2 * OP_W;

  logic signed [2*HI_W-1:0]    hh;
  logic signed [HI_W+LO_W:0]   hl;
  logic signed [HI_W+LO_W:0]   lh;
  logic        [2*LO_W-1:0]    ll;
  logic signed [P_W-1:0]       x_hh;
  logic signed [P_W-1:0]       x_mid;
  logic signed [P_W-1:0]       x_ll;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= $signed(a[OP_W-1:LO_W]) * $signed(b[OP_W-1:LO_W]);
      hl <= $signed(a[OP_W-1:LO_W]) * $signed({1'b0, b[LO_W-1:0]});
      lh <= $signed({1'b0, a[LO_W-1:0]}) * $signed(b[OP_W-1:LO_W]);
      ll <= a[LO_W-1:0] * b[LO_W-1:0];
    end
  end

  // stage 2: align and sum
  assign x_hh  = P_W'(hh) <<< (2 * LO_W);
  assign x_mid = (P_W'(hl) + P_W'(lh)) <<< LO_W;
  assign x_ll  = $signed({{(P_W-2*LO_W){1'b0}}, ll});

  always_ff @(posedge clk) begin
    if (en) begin
      p <= x_hh + x_mid + x_ll;
    end
  end

endmodule

// File: rtl/core/tbw_divider.sv
// Two-lane restoring divider with a shared divisor, one quotient bit per pipeline stage.
module tbw_divider #(
  parameter int NUM_W = 4 * tbw_pkg::TBW_COORD_BITS + tbw_pkg::TBW_FRAC_BITS + 11,
  parameter int DEN_W = 4 * tbw_pkg::TBW_COORD_BITS + 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  tbw_pkg::tbw_tag_t     in_tag,
  input  logic [NUM_W-1:0]      num_a,
  input  logic [NUM_W-1:0]      num_b,
  input  logic [DEN_W-1:0]      den,
  output logic                  out_valid,
  output tbw_pkg::tbw_tag_t     out_tag,
  output logic [NUM_W-1:0]      quo_a,
  output logic [NUM_W-1:0]      quo_b
);
  import tbw_pkg::*;

  logic [DEN_W-1:0] rem_a [NUM_W];
  logic [DEN_W-1:0] rem_b [NUM_W];
  logic [NUM_W-1:0] wrk_a [NUM_W];
  logic [NUM_W-1:0] wrk_b [NUM_W];
  logic [DEN_W-1:0] dens  [NUM_W];
  tbw_tag_t         tags  [NUM_W];
  logic             vals  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W-1:0] ra_in;
    logic [DEN_W-1:0] rb_in;
    logic [NUM_W-1:0] wa_in;
    logic [NUM_W-1:0] wb_in;
    logic [DEN_W-1:0] d_in;
    tbw_tag_t         t_in;
    logic             v_in;
    logic [DEN_W:0]   sh_a;
    logic [DEN_W:0]   sh_b;
    logic [DEN_W:0]   df_a;
    logic [DEN_W:0]   df_b;
    logic             ge_a;
    logic             ge_b;

    if (k == 0) begin : g_first
      assign ra_in = '0;
      assign rb_in = '0;
      assign wa_in = num_a;
      assign wb_in = num_b;
      assign d_in  = den;
      assign t_in  = in_tag;
      assign v_in  = in_valid;
    end else begin : g_rest
      assign ra_in = rem_a[k-1];
      assign rb_in = rem_b[k-1];
      assign wa_in = wrk_a[k-1];
      assign wb_in = wrk_b[k-1];
      assign d_in  = dens[k-1];
      assign t_in  = tags[k-1];
      assign v_in  = vals[k-1];
    end

    // bring down the next dividend bit and try the subtract
    assign sh_a = {ra_in, wa_in[NUM_W-1]};
    assign sh_b = {rb_in, wb_in[NUM_W-1]};
    assign df_a = sh_a - {1'b0, d_in};
    assign df_b = sh_b - {1'b0, d_in};
    assign ge_a = (sh_a >= {1'b0, d_in});
    assign ge_b = (sh_b >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vals[k] <= 1'b0;
      end else if (en) begin
        vals[k] <= v_in;
      end
    end

    // dividend bits shift out the top, quotient bits shift in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[k] <= ge_a ? df_a[DEN_W-1:0] : sh_a[DEN_W-1:0];
        rem_b[k] <= ge_b ? df_b[DEN_W-1:0] : sh_b[DEN_W-1:0];
        wrk_a[k] <= {wa_in[NUM_W-2:0], ge_a};
        wrk_b[k] <= {wb_in[NUM_W-2:0], ge_b};
        dens[k]  <= d_in;
        tags[k]  <= t_in;
      end
    end
  end

  assign out_valid = vals[NUM_W-1];
  assign out_tag   = tags[NUM_W-1];
  assign quo_a     = wrk_a[NUM_W-1];
  assign quo_b     = wrk_b[NUM_W-1];

endmodule

// File: rtl/core/triangle_barycentric_weights.sv
// Top level of the triangle barycentric weight pipeline.
//
// Takes one triangle and query point per cycle and returns the barycentric
// weights of the first two vertices as exact rounded quotients (ties away from
// zero) in signed Q(31-FRAC_BITS).FRAC_BITS, and the third weight as one minus
// the two, each saturated to 32 bits; a zero Gram determinant sets the
// degenerate flag in m_tuser with all weights zero. Throughput is one transfer
// per cycle while m_tready is high. The restoring divider resolves one quotient
// bit per stage. A stall on the output freezes the whole pipeline.
module triangle_barycentric_weights #(
  parameter int COORD_BITS = tbw_pkg::TBW_COORD_BITS,
  parameter int FRAC_BITS  = tbw_pkg::TBW_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z, point_x, point_y, point_z, zero pad
  input  logic [((tbw_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // weight_a, weight_b, weight_c
  output logic [3*tbw_pkg::WEIGHT_BITS-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);
  import tbw_pkg::*;

  localparam int DOT_W = 2 * COORD_BITS + 4;
  localparam int MUL_W = 2 * DOT_W;
  localparam int CR_W  = MUL_W + 1;
  localparam int NUM_W = CR_W + FRAC_BITS + 2;
  localparam int DEN_W = MUL_W + 1;
  localparam int SQ_W  = NUM_W + 1;
  localparam int WC_W  = NUM_W + 3;
  localparam int WB    = WEIGHT_BITS;

  logic en;
  logic dot_valid;
  logic signed [DOT_W-1:0] m00, m01, m11, r0, r1;
  logic signed [MUL_W-1:0] t_m00_m11, t_m01_m01, t_m11_r0, t_m01_r1, t_m00_r1, t_m01_r0;
  logic mul_v1, mul_v2;

  logic                   cr_valid;
  logic signed [CR_W-1:0] det, na, nb;
  logic                   cr_degen;

  logic             pr_valid;
  tbw_tag_t         pr_tag;
  logic [NUM_W-1:0] pr_num_a, pr_num_b;
  logic [DEN_W-1:0] pr_den;
  logic [CR_W-1:0]  mag_a, mag_b;

  logic             dv_valid;
  tbw_tag_t         dv_tag;
  logic [NUM_W-1:0] quo_a, quo_b;

  logic                   sg_valid;
  logic                   sg_degen;
  logic signed [SQ_W-1:0] sq_a, sq_b;

  logic                   wc_valid;
  logic                   wc_degen;
  logic signed [WC_W-1:0] wa, wb, wc;

  logic [WB-1:0] sat_a, sat_b, sat_c;

  // whole pipeline advances unless the output holds a result not yet taken
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  tbw_edge_dots #(
    .COORD_BITS (COORD_BITS)
  ) u_dots (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .coords    (s_tdata[NUM_COORDS*COORD_BITS-1:0]),
    .out_valid (dot_valid),
    .m00       (m00),
    .m01       (m01),
    .m11       (m11),
    .r0        (r0),
    .r1        (r1)
  );

  // Gram determinant and Cramer numerators
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_det0 (.clk(clk), .en(en), .a(m00), .b(m11), .p(t_m00_m11));
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_det1 (.clk(clk), .en(en), .a(m01), .b(m01), .p(t_m01_m01));
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_na0  (.clk(clk), .en(en), .a(m11), .b(r0),  .p(t_m11_r0));
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_na1  (.clk(clk), .en(en), .a(m01), .b(r1),  .p(t_m01_r1));
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_nb0  (.clk(clk), .en(en), .a(m00), .b(r1),  .p(t_m00_r1));
  tbw_wide_mul #(.OP_W(DOT_W)) u_mul_nb1  (.clk(clk), .en(en), .a(m01), .b(r0),  .p(t_m01_r0));

  // valid bits for the stages outside the submodules
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v1   <= 1'b0;
      mul_v2   <= 1'b0;
      cr_valid <= 1'b0;
      pr_valid <= 1'b0;
      sg_valid <= 1'b0;
      wc_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      mul_v1   <= dot_valid;
      mul_v2   <= mul_v1;
      cr_valid <= mul_v2;
      pr_valid <= cr_valid;
      sg_valid <= dv_valid;
      wc_valid <= sg_valid;
      m_tvalid <= wc_valid;
    end
  end

  // magnitudes of the numerators
  assign mag_a = na[CR_W-1] ? CR_W'(-na) : CR_W'(na);
  assign mag_b = nb[CR_W-1] ? CR_W'(-nb) : CR_W'(nb);

  // saturation to the weight width
  assign sat_a = (&wa[WC_W-1:WB-1] | ~|wa[WC_W-1:WB-1]) ? wa[WB-1:0]
               : (wa[WC_W-1] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}});
  assign sat_b = (&wb[WC_W-1:WB-1] | ~|wb[WC_W-1:WB-1]) ? wb[WB-1:0]
               : (wb[WC_W-1] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}});
  assign sat_c = (&wc[WC_W-1:WB-1] | ~|wc[WC_W-1:WB-1]) ? wc[WB-1:0]
               : (wc[WC_W-1] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}});

  // determinant, numerators, divider operands
  always_ff @(posedge clk) begin
    if (en) begin
      det      <= CR_W'(t_m00_m11) - CR_W'(t_m01_m01);
      na       <= CR_W'(t_m11_r0) - CR_W'(t_m01_r1);
      nb       <= CR_W'(t_m00_r1) - CR_W'(t_m01_r0);
      cr_degen <= (CR_W'(t_m00_m11) - CR_W'(t_m01_m01)) <= 0;

      // round to nearest: (2*|n|*2^F + det) / (2*det)
      pr_num_a          <= (NUM_W'(mag_a) << (FRAC_BITS + 1)) + NUM_W'(det[MUL_W-1:0]);
      pr_num_b          <= (NUM_W'(mag_b) << (FRAC_BITS + 1)) + NUM_W'(det[MUL_W-1:0]);
      pr_den            <= {det[MUL_W-1:0], 1'b0};
      pr_tag.neg_a      <= na[CR_W-1];
      pr_tag.neg_b      <= nb[CR_W-1];
      pr_tag.degenerate <= cr_degen;
    end
  end

  tbw_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_valid),
    .in_tag    (pr_tag),
    .num_a     (pr_num_a),
    .num_b     (pr_num_b),
    .den       (pr_den),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .quo_a     (quo_a),
    .quo_b     (quo_b)
  );

  // restore signs, form the third weight, saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      sq_a     <= dv_tag.neg_a ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
      sq_b     <= dv_tag.neg_b ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});
      sg_degen <= dv_tag.degenerate;

      wa       <= WC_W'(sq_a);
      wb       <= WC_W'(sq_b);
      wc       <= (WC_W'(1) <<< FRAC_BITS) - WC_W'(sq_a) - WC_W'(sq_b);
      wc_degen <= sg_degen;

      m_tdata  <= wc_degen ? '0 : {sat_c, sat_b, sat_a};
      m_tuser  <= wc_degen;
    end
  end

endmodule
